### rtl/lzd_pkg.sv
`default_nettype none
package lzd_pkg;

	// history window
	localparam int WINDOW_SIZE = 4096;
	localparam int WIN_BITS    = $clog2(WINDOW_SIZE);

	// size field of the header
	localparam int HDR_SIZE_BITS = 24;
	localparam int SIZE_BITS_DEF = 24;

	// match token geometry
	localparam int LEN_BITS  = 5;
	localparam int LEN_BIAS  = 3;
	localparam int DIST_BITS = WIN_BITS + 1;

	// last header byte index and top flag bit
	localparam logic [1:0] HDR_LAST = 2'd3;
	localparam logic [2:0] FLAG_TOP = 3'd7;

	typedef enum logic [2:0] {
		ST_HEADER,
		ST_FLAG,
		ST_TOKEN,
		ST_MATCH,
		ST_COPY_RD,
		ST_COPY_WR
	} lzd_state_t;

	// history memory access for one cycle
	typedef struct packed {
		logic                we;
		logic [WIN_BITS-1:0] waddr;
		logic [7:0]          wdata;
		logic                re;
		logic [WIN_BITS-1:0] raddr;
	} lzd_hist_req_t;

endpackage
`default_nettype wire

### rtl/lz77_stream_decompressor_core.sv
`default_nettype none
// A literal word shows on the output in the cycle after it is taken. The first byte
// of a match passes the ST_COPY_RD history read and ST_COPY_WR emit before the output
// register. Throughput: header and flag words go one per cycle, literal words likewise
// when not stalled; a match byte is read from history, then emitted and written back.
// Reset clears all control state and the output valid flag; the 4 KiB history is not
// cleared and needs no clearing pass, since a match only reads bytes of its own stream.
module lz77_stream_decompressor_core
	import lzd_pkg::*;
#(
	parameter int SIZE_BITS = SIZE_BITS_DEF
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_stall,
	input  wire  [7:0] in_byte,
	output logic       out_valid,
	input  wire        out_stall,
	output logic [7:0] out_byte,
	output logic       last_byte,
	output logic       bad_reference
);

	localparam int CMP_BITS = (SIZE_BITS > DIST_BITS) ? SIZE_BITS : DIST_BITS;

	lzd_state_t state_q, state_d;
	logic [1:0]           hdr_cnt_q;
	logic [SIZE_BITS-1:0] size_q;
	logic [SIZE_BITS-1:0] pos_q;
	logic [7:0]           flags_q;
	logic [2:0]           bit_idx_q;
	logic [7:0]           mfirst_q;
	logic [LEN_BITS-1:0]  rem_q;
	logic [DIST_BITS-1:0] dist_q;

	logic                 out_valid_q;
	logic [7:0]           out_byte_q;
	logic                 out_last_q;
	logic                 out_bad_q;

	logic                 slot_free;
	logic                 in_take;
	logic                 cur_bit;
	logic [SIZE_BITS-1:0] pos_inc;
	logic                 done_next;
	logic                 copy_bad;
	logic                 copy_end;
	lzd_state_t           fin_state;
	logic                 fin_dec;
	logic [HDR_SIZE_BITS-1:0] hdr_shift;
	logic [SIZE_BITS-1:0] size_new;

	logic                 emit_vld;
	logic [7:0]           emit_byte;
	logic                 emit_bad;
	logic                 emit_last;
	lzd_hist_req_t        hist_req;
	logic [7:0]           hist_rdata;

	lzd_history u_history (
		.clk   (clk),
		.req   (hist_req),
		.rdata (hist_rdata)
	);

	// common decodes
	assign slot_free = !out_valid_q || !out_stall;
	assign in_take   = in_valid && !in_stall;
	assign cur_bit   = flags_q[bit_idx_q];
	assign pos_inc   = pos_q + 1'b1;
	assign done_next = pos_inc >= size_q;
	assign emit_last = pos_inc == size_q;
	assign copy_bad  = CMP_BITS'(pos_q) < CMP_BITS'(dist_q);
	assign copy_end  = (rem_q == LEN_BITS'(1)) || done_next;

	// where a finished token leads
	assign fin_state = done_next ? ST_HEADER : ((bit_idx_q == 3'd0) ? ST_FLAG : ST_TOKEN);
	assign fin_dec   = !done_next && (bit_idx_q != 3'd0);

	// size byte accumulation, low byte first
	always_comb begin
		case (hdr_cnt_q)
			2'd1:    hdr_shift = {16'd0, in_byte};
			2'd2:    hdr_shift = {8'd0, in_byte, 8'd0};
			2'd3:    hdr_shift = {in_byte, 16'd0};
			default: hdr_shift = '0;
		endcase
		size_new = (hdr_cnt_q == 2'd0) ? '0 : (size_q | SIZE_BITS'(hdr_shift));
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_HEADER: begin
				if (in_take && hdr_cnt_q == HDR_LAST) begin
					state_d = (size_new == '0) ? ST_HEADER : ST_FLAG;
				end
			end
			ST_FLAG: begin
				if (in_take) state_d = ST_TOKEN;
			end
			ST_TOKEN: begin
				if (in_take) state_d = cur_bit ? ST_MATCH : fin_state;
			end
			ST_MATCH: begin
				if (in_take) state_d = ST_COPY_RD;
			end
			ST_COPY_RD: state_d = ST_COPY_WR;
			ST_COPY_WR: begin
				if (slot_free) state_d = copy_end ? fin_state : ST_COPY_RD;
			end
			default: state_d = ST_HEADER;
		endcase
	end

	// handshake, emit and history access
	always_comb begin
		in_stall       = 1'b1;
		emit_vld       = 1'b0;
		emit_byte      = in_byte;
		emit_bad       = 1'b0;
		hist_req.re    = 1'b0;
		hist_req.raddr = WIN_BITS'(pos_q) - dist_q[WIN_BITS-1:0];
		case (state_q)
			ST_HEADER, ST_FLAG, ST_MATCH: in_stall = 1'b0;
			ST_TOKEN: begin
				in_stall = !cur_bit && !slot_free;
				emit_vld = in_valid && !cur_bit && slot_free;
			end
			ST_COPY_RD: hist_req.re = 1'b1;
			ST_COPY_WR: begin
				emit_vld  = slot_free;
				emit_bad  = copy_bad;
				emit_byte = copy_bad ? 8'd0 : hist_rdata;
			end
			default: in_stall = 1'b1;
		endcase
		hist_req.we    = emit_vld;
		hist_req.waddr = WIN_BITS'(pos_q);
		hist_req.wdata = emit_byte;
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HEADER;
		end else begin
			state_q <= state_d;
		end
	end

	// decoder context
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_cnt_q <= '0;
			size_q    <= '0;
			pos_q     <= '0;
			flags_q   <= '0;
			bit_idx_q <= FLAG_TOP;
			mfirst_q  <= '0;
			rem_q     <= '0;
			dist_q    <= '0;
		end else begin
			case (state_q)
				ST_HEADER: begin
					if (in_take) begin
						size_q    <= size_new;
						hdr_cnt_q <= hdr_cnt_q + 1'b1;
						if (hdr_cnt_q == HDR_LAST) begin
							pos_q     <= '0;
							bit_idx_q <= FLAG_TOP;
						end
					end
				end
				ST_FLAG: begin
					if (in_take) begin
						flags_q   <= in_byte;
						bit_idx_q <= FLAG_TOP;
					end
				end
				ST_TOKEN: begin
					if (in_take) begin
						if (cur_bit) begin
							mfirst_q <= in_byte;
						end else begin
							pos_q <= pos_inc;
							if (fin_dec) bit_idx_q <= bit_idx_q - 1'b1;
						end
					end
				end
				ST_MATCH: begin
					if (in_take) begin
						rem_q  <= LEN_BITS'(mfirst_q[7:4]) + LEN_BITS'(LEN_BIAS);
						dist_q <= {1'b0, mfirst_q[3:0], in_byte} + 1'b1;
					end
				end
				ST_COPY_WR: begin
					if (slot_free) begin
						pos_q <= pos_inc;
						rem_q <= rem_q - 1'b1;
						if (copy_end && fin_dec) bit_idx_q <= bit_idx_q - 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (slot_free) begin
			out_valid_q <= emit_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_vld) begin
			out_byte_q <= emit_byte;
			out_last_q <= emit_last;
			out_bad_q  <= emit_bad;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_byte      = out_byte_q;
	assign last_byte     = out_last_q;
	assign bad_reference = out_bad_q;

`ifndef SYNTHESIS
	// window port is never read and written in the same cycle
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(hist_req.we && hist_req.re))
		else $error("history read and write in the same cycle");

	// copy only runs below the declared size
	a_copy_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COPY_WR) |-> (pos_q < size_q))
		else $error("match copy past declared size");

	// a read is only issued with bytes left to copy
	a_copy_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COPY_RD) |-> (rem_q != '0))
		else $error("match copy with zero remaining");

	// final byte of a stream returns the decoder to the header
	a_last_to_header: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_vld && emit_last) |=> (state_q == ST_HEADER))
		else $error("last byte emitted without return to header");
`endif

endmodule
`default_nettype wire

### rtl/lzd_history.sv
`default_nettype none
module lzd_history
	import lzd_pkg::*;
(
	input  wire           clk,
	input  wire lzd_hist_req_t req,
	output logic [7:0]    rdata
);

	logic [7:0] mem [WINDOW_SIZE];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata <= mem[req.raddr];
		end
	end

endmodule
`default_nettype wire
